// ===== rtl/ncpe_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ncpe_pkg
// Shared types and constants of the NURBS curve point evaluator.
// ---------------------------------------------------------------------------
package ncpe_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_ORDER  = 7;
    localparam int FRAC_BITS  = 16;
    localparam int KNOT_DEPTH = MAX_POINTS + MAX_ORDER + 1;

    localparam int KNOT_AW = $clog2(KNOT_DEPTH);
    localparam int PT_AW   = $clog2(MAX_POINTS);
    localparam int IDX_W   = 7;
    localparam int NB_AW   = $clog2(MAX_ORDER + 2);

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 104;
    localparam int CFG_AW    = 1;
    localparam int CFG_DW    = 7;
    localparam int PT_W      = 31 + 3 * 32;

    localparam logic [CFG_AW-1:0] CFG_CURVE_ORDER = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_POINT_COUNT = 1'b1;

    localparam logic signed [31:0] ONE_FX  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] ACC_LIM = 64'sh7fff_ffff_ffff_ffff;

    typedef enum logic [1:0] {
        REQ_KNOT  = 2'd0,
        REQ_POINT = 2'd1,
        REQ_EVAL  = 2'd2
    } req_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] dividend;
        logic signed [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [31:0] quot;
    } div_rsp_t;

endpackage

// ===== rtl/nurbs_curve_point_eval.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nurbs_curve_point_eval
// Rational B-spline curve point evaluator over knot and control point RAMs.
// Load transactions write the RAMs when accepted. An evaluate transaction runs a
// knot search that skips repeated knots, then p*(p+3)/2 basis steps for degree p,
// each with up to two divisions, a weighted-point step per control point of the
// span and three final divisions (none when the denominator is zero); basis and
// final divisions share one divider. One transaction at a time.
// Reset sets degree 3 and 4 control points; the tables are not cleared.
// ---------------------------------------------------------------------------
module nurbs_curve_point_eval (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ncpe_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [ncpe_pkg::CFG_DW-1:0]    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index, param_value, point_weight, coord_x, coord_y, coord_z
    input  logic [ncpe_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // point_x, point_y, point_z, segment_found
    output logic [ncpe_pkg::M_TDATA_W-1:0] m_tdata,
    // zero_denominator, saturated
    output logic [1:0]                     m_tuser
);
    import ncpe_pkg::*;

    typedef enum logic [28:0] {
        ST_IDLE = 29'h0000001, ST_SI_A = 29'h0000002, ST_SI_B = 29'h0000004,
        ST_SI_C = 29'h0000008, ST_SJ_A = 29'h0000010, ST_SJ_B = 29'h0000020,
        ST_SJ_C = 29'h0000040, ST_SMID = 29'h0000080, ST_SMC  = 29'h0000100,
        ST_BA   = 29'h0000200, ST_BB   = 29'h0000400, ST_BC   = 29'h0000800,
        ST_BD   = 29'h0001000, ST_BE   = 29'h0002000, ST_T1   = 29'h0004000,
        ST_W1   = 29'h0008000, ST_T2   = 29'h0010000, ST_W2   = 29'h0020000,
        ST_WR   = 29'h0040000, ST_PA   = 29'h0080000, ST_PB   = 29'h0100000,
        ST_PC   = 29'h0200000, ST_PD   = 29'h0400000, ST_PE   = 29'h0800000,
        ST_FA   = 29'h1000000, ST_FZ   = 29'h2000000, ST_FD   = 29'h4000000,
        ST_FW   = 29'h8000000, ST_OUT  = 29'h10000000
    } state_t;

    function automatic logic [32:0] clip32(input logic signed [63:0] v);
        if (v > 64'(S32_MAX)) begin
            return {1'b1, S32_MAX};
        end else if (v < 64'(S32_MIN)) begin
            return {1'b1, S32_MIN};
        end
        return {1'b0, v[31:0]};
    endfunction

    state_t state_reg;

    logic [2:0]       cfg_order_reg;
    logic [IDX_W-1:0] cfg_count_reg;

    logic [2:0]       ord_reg;
    logic [IDX_W-1:0] nc_reg;
    logic [IDX_W-1:0] i_reg, j_reg, k_reg, base_reg;
    logic [3:0]       r_reg, p_reg;
    logic [1:0]       d_reg;

    logic signed [31:0] t_reg;
    logic signed [31:0] ka_reg, kb_reg, kc_reg, kd_reg;
    logic signed [31:0] carry_reg;
    logic signed [32:0] sum_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] b_reg;
    logic signed [35:0] den_reg;
    logic signed [63:0] acc_reg [0:2];
    logic        [31:0] res_reg [0:2];
    logic signed [31:0] nb_reg  [0:MAX_ORDER+1];
    logic               sat_reg, zden_reg;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [1:0]           out_user_reg;

    // input fields
    req_t               in_req;
    logic [IDX_W-1:0]   in_idx;
    logic signed [31:0] in_param;
    logic        [30:0] in_weight;
    logic        [95:0] in_coords;
    logic               accept;

    assign in_req    = req_t'(s_tuser);
    assign in_idx    = s_tdata[6:0];
    assign in_param  = s_tdata[38:7];
    assign in_weight = s_tdata[69:39];
    assign in_coords = s_tdata[165:70];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    // knot and point memories
    logic               kn_we, pt_we;
    logic [KNOT_AW-1:0] kn_raddr;
    logic [31:0]        kn_rdata;
    logic [PT_AW-1:0]   pt_raddr;
    logic [PT_W-1:0]    pt_rdata;

    assign kn_we = accept && (in_req == REQ_KNOT) && (in_idx < IDX_W'(KNOT_DEPTH));
    assign pt_we = accept && (in_req == REQ_POINT) && (in_idx < IDX_W'(MAX_POINTS));

    ncpe_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_knot_ram (
        .aclk  (aclk),
        .we    (kn_we),
        .waddr (in_idx[KNOT_AW-1:0]),
        .wdata (in_param),
        .raddr (kn_raddr),
        .rdata (kn_rdata)
    );

    ncpe_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (in_idx[PT_AW-1:0]),
        .wdata ({in_coords, in_weight}),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    // address arithmetic
    logic [IDX_W-1:0] ord7, p7, r7, idx_i, mid;
    assign ord7  = IDX_W'(ord_reg);
    assign p7    = IDX_W'(p_reg);
    assign r7    = IDX_W'(r_reg);
    assign idx_i = base_reg + p7;
    assign mid   = IDX_W'(({1'b0, i_reg} + {1'b0, j_reg}) >> 1);

    always_comb begin
        kn_raddr = '0;
        unique case (state_reg)
            ST_SI_A: kn_raddr = i_reg;
            ST_SI_B: kn_raddr = i_reg + 7'd1;
            ST_SJ_A: kn_raddr = j_reg - 7'd1;
            ST_SJ_B: kn_raddr = j_reg;
            ST_SMID: kn_raddr = mid;
            ST_BA:   kn_raddr = idx_i;
            ST_BB:   kn_raddr = idx_i + r7;
            ST_BC:   kn_raddr = idx_i + 7'd1;
            ST_BD:   kn_raddr = idx_i + r7 + 7'd1;
            default: kn_raddr = '0;
        endcase
    end

    assign pt_raddr = (state_reg == ST_FA) ? '0 : idx_i[PT_AW-1:0];

    // basis buffer read, p+1 during the triangle, p during weighting
    logic [NB_AW-1:0]   nb_ridx;
    logic signed [31:0] nb_rd;
    assign nb_ridx = (state_reg == ST_PB) ? p_reg : p_reg + 4'd1;
    assign nb_rd   = nb_reg[nb_ridx];

    // point fields
    logic        [30:0] pt_w;
    logic signed [31:0] pt_c [0:2];
    logic signed [31:0] pt_sel;
    assign pt_w    = pt_rdata[30:0];
    assign pt_c[0] = pt_rdata[62:31];
    assign pt_c[1] = pt_rdata[94:63];
    assign pt_c[2] = pt_rdata[126:95];
    assign pt_sel  = (d_reg == 2'd0) ? pt_c[0] : ((d_reg == 2'd1) ? pt_c[1] : pt_c[2]);

    // basis term operands
    logic signed [32:0] span1, span2, diff1, diff2;
    logic signed [64:0] mul1, mul2;
    assign span1 = 33'(kb_reg) - 33'(ka_reg);
    assign span2 = 33'(kd_reg) - 33'(kc_reg);
    assign diff1 = 33'(t_reg) - 33'(ka_reg);
    assign diff2 = 33'(kd_reg) - 33'(t_reg);
    assign mul1  = diff1 * carry_reg;
    assign mul2  = diff2 * nb_rd;

    // shared divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = mul1[63:0];
        div_req.divisor  = 64'(span1);
        unique case (state_reg)
            ST_T1: div_req.start = (span1 != 33'sd0);
            ST_T2: begin
                div_req.start    = (span2 != 33'sd0);
                div_req.dividend = mul2[63:0];
                div_req.divisor  = 64'(span2);
            end
            ST_FD: begin
                div_req.start    = 1'b1;
                div_req.dividend = acc_reg[d_reg];
                div_req.divisor  = 64'(den_reg);
            end
            default: div_req.start = 1'b0;
        endcase
    end

    ncpe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // weighted basis, truncated toward zero
    logic signed [63:0] wshift;
    logic [32:0]        wclip;
    assign wshift = (prod_reg >>> FRAC_BITS) +
                    64'((prod_reg[63] && (prod_reg[FRAC_BITS-1:0] != '0)) ? 1 : 0);
    assign wclip  = clip32(wshift);

    // saturating accumulate
    logic signed [64:0] acc_sum;
    logic signed [63:0] acc_new;
    logic               acc_sat;
    always_comb begin
        acc_sum = 65'(acc_reg[d_reg]) + 65'(prod_reg);
        acc_sat = 1'b0;
        acc_new = acc_sum[63:0];
        if (acc_sum > 65'(ACC_LIM)) begin
            acc_sat = 1'b1;
            acc_new = ACC_LIM;
        end else if (acc_sum < -65'(ACC_LIM)) begin
            acc_sat = 1'b1;
            acc_new = -ACC_LIM;
        end
    end

    logic [32:0] sum_clip;
    assign sum_clip = clip32(64'(sum_reg));

    // clamped configuration for a new evaluation
    logic [2:0]       ord_c;
    logic [IDX_W-1:0] nc_lo, nc_c;
    assign ord_c = (cfg_order_reg == 3'd0) ? 3'd1 : cfg_order_reg;
    assign nc_lo = IDX_W'(ord_c) + 7'd1;
    assign nc_c  = (cfg_count_reg < nc_lo) ? nc_lo :
                   ((cfg_count_reg > IDX_W'(MAX_POINTS)) ? IDX_W'(MAX_POINTS) : cfg_count_reg);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_order_reg <= 3'd3;
            cfg_count_reg <= 7'd4;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_CURVE_ORDER: cfg_order_reg <= cfg_wdata[2:0];
                    CFG_POINT_COUNT: cfg_count_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: if (accept && in_req == REQ_EVAL) state_reg <= ST_SI_A;
                ST_SI_A: state_reg <= (i_reg < nc_reg - 7'd1) ? ST_SI_B : ST_SJ_A;
                ST_SI_B: state_reg <= ST_SI_C;
                ST_SI_C: state_reg <= (kn_rdata == ka_reg) ? ST_SI_A : ST_SJ_A;
                ST_SJ_A: state_reg <= (j_reg > i_reg + 7'd1) ? ST_SJ_B : ST_SMID;
                ST_SJ_B: state_reg <= ST_SJ_C;
                ST_SJ_C: state_reg <= (kn_rdata == ka_reg) ? ST_SJ_A : ST_SMID;
                ST_SMID: state_reg <= (j_reg <= i_reg + 7'd1) ? ST_BA : ST_SMC;
                ST_SMC:  state_reg <= ST_SI_A;
                ST_BA:   state_reg <= ST_BB;
                ST_BB:   state_reg <= ST_BC;
                ST_BC:   state_reg <= ST_BD;
                ST_BD:   state_reg <= ST_BE;
                ST_BE:   state_reg <= ST_T1;
                ST_T1:   state_reg <= (span1 != 33'sd0) ? ST_W1 : ST_T2;
                ST_W1:   if (div_rsp.done) state_reg <= ST_T2;
                ST_T2:   state_reg <= (span2 != 33'sd0) ? ST_W2 : ST_WR;
                ST_W2:   if (div_rsp.done) state_reg <= ST_WR;
                ST_WR: begin
                    if (p_reg == {1'b0, ord_reg} && r_reg == {1'b0, ord_reg}) begin
                        state_reg <= ST_PA;
                    end else begin
                        state_reg <= ST_BA;
                    end
                end
                ST_PA:   state_reg <= ST_PB;
                ST_PB:   state_reg <= ST_PC;
                ST_PC:   state_reg <= ST_PD;
                ST_PD:   state_reg <= ST_PE;
                ST_PE: begin
                    if (d_reg == 2'd2) begin
                        state_reg <= (p_reg == {1'b0, ord_reg}) ? ST_FA : ST_PA;
                    end else begin
                        state_reg <= ST_PD;
                    end
                end
                ST_FA:   state_reg <= (den_reg == 36'sd0) ? ST_FZ : ST_FD;
                ST_FZ:   state_reg <= ST_OUT;
                ST_FD:   state_reg <= ST_FW;
                ST_FW:   if (div_rsp.done) state_reg <= (d_reg == 2'd2) ? ST_OUT : ST_FD;
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                t_reg    <= in_param;
                ord_reg  <= ord_c;
                nc_reg   <= nc_c;
                i_reg    <= IDX_W'(ord_c);
                j_reg    <= nc_c;
                sat_reg  <= 1'b0;
                zden_reg <= 1'b0;
                for (int n = 0; n <= MAX_ORDER + 1; n++) begin
                    nb_reg[n] <= (n == int'(ord_c)) ? ONE_FX : 32'sd0;
                end
            end
            ST_SI_B: ka_reg <= kn_rdata;
            ST_SI_C: if (kn_rdata == ka_reg) i_reg <= i_reg + 7'd1;
            ST_SJ_B: ka_reg <= kn_rdata;
            ST_SJ_C: if (kn_rdata == ka_reg) j_reg <= j_reg - 7'd1;
            ST_SMID: begin
                k_reg     <= mid;
                base_reg  <= i_reg - ord7;
                r_reg     <= 4'd1;
                p_reg     <= {1'b0, ord_reg} - 4'd1;
                carry_reg <= 32'sd0;
            end
            ST_SMC: begin
                if ($signed(kn_rdata) > t_reg) begin
                    j_reg <= k_reg;
                end else begin
                    i_reg <= k_reg;
                end
            end
            ST_BB: ka_reg <= kn_rdata;
            ST_BC: kb_reg <= kn_rdata;
            ST_BD: kc_reg <= kn_rdata;
            ST_BE: kd_reg <= kn_rdata;
            ST_T1: sum_reg <= 33'sd0;
            ST_W1: begin
                if (div_rsp.done) begin
                    sum_reg <= 33'($signed(div_rsp.quot));
                    sat_reg <= sat_reg | div_rsp.sat;
                end
            end
            ST_W2: begin
                if (div_rsp.done) begin
                    sum_reg <= sum_reg + 33'($signed(div_rsp.quot));
                    sat_reg <= sat_reg | div_rsp.sat;
                end
            end
            ST_WR: begin
                nb_reg[p_reg] <= sum_clip[31:0];
                sat_reg       <= sat_reg | sum_clip[32];
                if (p_reg == {1'b0, ord_reg}) begin
                    if (r_reg == {1'b0, ord_reg}) begin
                        p_reg      <= 4'd0;
                        den_reg    <= 36'sd0;
                        acc_reg[0] <= 64'sd0;
                        acc_reg[1] <= 64'sd0;
                        acc_reg[2] <= 64'sd0;
                    end else begin
                        r_reg     <= r_reg + 4'd1;
                        p_reg     <= {1'b0, ord_reg} - r_reg - 4'd1;
                        carry_reg <= 32'sd0;
                    end
                end else begin
                    p_reg     <= p_reg + 4'd1;
                    carry_reg <= nb_rd;
                end
            end
            ST_PB: prod_reg <= $signed({1'b0, pt_w}) * nb_rd;
            ST_PC: begin
                b_reg   <= wclip[31:0];
                sat_reg <= sat_reg | wclip[32];
                den_reg <= den_reg + 36'($signed(wclip[31:0]));
                d_reg   <= 2'd0;
            end
            ST_PD: prod_reg <= b_reg * pt_sel;
            ST_PE: begin
                acc_reg[d_reg] <= acc_new;
                sat_reg        <= sat_reg | acc_sat;
                if (d_reg == 2'd2) begin
                    p_reg <= p_reg + 4'd1;
                end else begin
                    d_reg <= d_reg + 2'd1;
                end
            end
            ST_FA: begin
                d_reg    <= 2'd0;
                zden_reg <= (den_reg == 36'sd0);
            end
            ST_FZ: begin
                res_reg[0] <= pt_c[0];
                res_reg[1] <= pt_c[1];
                res_reg[2] <= pt_c[2];
            end
            ST_FW: begin
                if (div_rsp.done) begin
                    res_reg[d_reg] <= div_rsp.quot;
                    sat_reg        <= sat_reg | div_rsp.sat;
                    d_reg          <= d_reg + 2'd1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_data_reg <= {1'b0, i_reg, res_reg[2], res_reg[1], res_reg[0]};
                    out_user_reg <= {sat_reg, zden_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/ncpe_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ncpe_ram
// Simple dual-port synchronous RAM, one write port, registered read port.
// ---------------------------------------------------------------------------
module ncpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ncpe_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ncpe_div
// Radix-2 restoring signed divider, truncating, result clipped to 32 bits.
// ---------------------------------------------------------------------------
module ncpe_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  ncpe_pkg::div_req_t req,
    output ncpe_pkg::div_rsp_t rsp
);
    import ncpe_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic        neg_reg;

    logic [64:0] rem_sh;
    logic        qbit;
    logic [64:0] rem_sub;

    assign rem_sh  = {rem_reg, num_reg[63]};
    assign qbit    = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 6'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= 6'd63;
            num_reg <= req.dividend[63] ? (~req.dividend + 64'd1) : req.dividend;
            den_reg <= req.divisor[63] ? (~req.divisor + 64'd1) : req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= req.dividend[63] ^ req.divisor[63];
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            num_reg <= {num_reg[62:0], 1'b0};
            rem_reg <= qbit ? rem_sub[63:0] : rem_sh[63:0];
            quo_reg <= {quo_reg[62:0], qbit};
        end
    end

    // clip the signed quotient to the 32-bit range
    always_comb begin
        rsp.done = done_reg;
        rsp.sat  = 1'b0;
        if (neg_reg) begin
            if (quo_reg > 64'h0000_0000_8000_0000) begin
                rsp.sat  = 1'b1;
                rsp.quot = S32_MIN;
            end else begin
                rsp.quot = ~quo_reg[31:0] + 32'd1;
            end
        end else begin
            if (quo_reg > 64'h0000_0000_7fff_ffff) begin
                rsp.sat  = 1'b1;
                rsp.quot = S32_MAX;
            end else begin
                rsp.quot = quo_reg[31:0];
            end
        end
    end

endmodule

// ===== tb/tb_nurbs_curve_point_eval.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nurbs_curve_point_eval
// Loads knot and control point tables, evaluates curve points and checks each
// result against an in-bench fixed-point NURBS predictor or a directed value, under random
// back-pressure, idle gaps and several degree/point-count settings.
// ---------------------------------------------------------------------------
module tb_nurbs_curve_point_eval;
    import ncpe_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int ITEM_TARGET = 1800;
    localparam int WDOG_LIMIT  = 60000;
    localparam int LONG_HOLD   = 15000;
    localparam longint ACC_MAX = 64'sh7fff_ffff_ffff_ffff;

    typedef struct {
        logic [1:0]  req;
        logic [6:0]  idx;
        logic [31:0] param;
        logic [30:0] weight;
        logic [31:0] cx, cy, cz;
    } load_item_t;

    typedef struct {
        logic [31:0] px, py, pz;
        logic [6:0]  seg;
        logic        zden;
        logic        sat;
    } curve_pt_t;

    typedef struct {
        load_item_t  it;
        bit          has_exp;
        curve_pt_t   pt;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_AW-1:0]    cfg_addr;
    logic [CFG_DW-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    nurbs_curve_point_eval i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // predictor state
    longint    knot_mem [KNOT_DEPTH];
    longint    wgt_mem  [MAX_POINTS];
    longint    pt_mem   [MAX_POINTS][3];
    int        degree_reg;
    int        count_reg;

    curve_pt_t pending_pts[$];
    int        errors;
    int        items_sent;
    bit        idle_on;
    bit        long_hold_req;
    int        quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint clip32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic int eff_degree();
        int d;
        d = degree_reg;
        if (d < 1) d = 1;
        if (d > MAX_ORDER) d = MAX_ORDER;
        return d;
    endfunction

    function automatic int eff_count();
        int n;
        n = count_reg;
        if (n < eff_degree() + 1) n = eff_degree() + 1;
        if (n > MAX_POINTS) n = MAX_POINTS;
        return n;
    endfunction

    function automatic int search_segment(int ord, int nc, longint t);
        int i;
        int j;
        int k;
        i = ord;
        j = nc;
        forever begin
            while (i < nc - 1 && knot_mem[i+1] == knot_mem[i]) i++;
            while (j > i + 1 && knot_mem[j-1] == knot_mem[j]) j--;
            if (j <= i + 1) break;
            k = (i + j) / 2;
            if (knot_mem[k] > t) j = k;
            else i = k;
        end
        return i;
    endfunction

    function automatic curve_pt_t eval_curve_point(longint t);
        curve_pt_t res;
        longint    nb [MAX_ORDER+2];
        longint    acc [3];
        longint    den;
        longint    span;
        longint    sum;
        longint    b;
        longint    lim;
        int        ord, nc, seg, base, i;
        bit        sat;
        ord = eff_degree();
        nc  = eff_count();
        sat = 0;
        den = 0;
        foreach (nb[q]) nb[q] = 0;
        foreach (acc[q]) acc[q] = 0;
        seg  = search_segment(ord, nc, t);
        base = seg - ord;
        nb[ord] = 64'sd1 <<< FRAC_BITS;
        for (int r = 1; r <= ord; r++) begin
            for (int p = ord - r; p <= ord; p++) begin
                i = base + p;
                sum = 0;
                span = knot_mem[i+r] - knot_mem[i];
                if (span != 0)
                    sum += clip32(((t - knot_mem[i]) * nb[p]) / span, sat);
                span = knot_mem[i+r+1] - knot_mem[i+1];
                if (span != 0)
                    sum += clip32(((knot_mem[i+r+1] - t) * nb[p+1]) / span, sat);
                nb[p] = clip32(sum, sat);
            end
        end
        for (int p = 0; p <= ord; p++) begin
            i = base + p;
            b = clip32((wgt_mem[i] * nb[p]) / (64'sd1 <<< FRAC_BITS), sat);
            den += b;
            for (int d = 0; d < 3; d++) begin
                lim = b * pt_mem[i][d];
                // accumulator saturates symmetrically
                if (lim > 0 && acc[d] > ACC_MAX - lim) begin
                    sat = 1;
                    acc[d] = ACC_MAX;
                end else if (lim < 0 && acc[d] < -ACC_MAX - lim) begin
                    sat = 1;
                    acc[d] = -ACC_MAX;
                end else begin
                    acc[d] = acc[d] + lim;
                end
            end
        end
        res.zden = (den == 0);
        if (den == 0) begin
            res.px = pt_mem[0][0][31:0];
            res.py = pt_mem[0][1][31:0];
            res.pz = pt_mem[0][2][31:0];
        end else begin
            res.px = 32'(clip32(acc[0] / den, sat));
            res.py = 32'(clip32(acc[1] / den, sat));
            res.pz = 32'(clip32(acc[2] / den, sat));
        end
        res.seg = seg[6:0];
        res.sat = sat;
        return res;
    endfunction

    // updates the tables; returns 1 when the item yields a curve point
    function automatic bit apply_item(load_item_t it, output curve_pt_t pt);
        pt = '{default: '0};
        case (it.req)
            REQ_KNOT: begin
                if (it.idx < KNOT_DEPTH) knot_mem[it.idx] = sx32(it.param);
                return 0;
            end
            REQ_POINT: begin
                if (it.idx < MAX_POINTS) begin
                    wgt_mem[it.idx]   = longint'(it.weight);
                    pt_mem[it.idx][0] = sx32(it.cx);
                    pt_mem[it.idx][1] = sx32(it.cy);
                    pt_mem[it.idx][2] = sx32(it.cz);
                end
                return 0;
            end
            REQ_EVAL: begin
                pt = eval_curve_point(sx32(it.param));
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic send_item(load_item_t it, bit has_exp = 0, curve_pt_t typed = '{default: '0});
        curve_pt_t pt;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.req;
        s_tdata  <= {2'b00, it.cz, it.cy, it.cx, it.weight, it.param, it.idx};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (apply_item(it, pt)) pending_pts.push_back(has_exp ? typed : pt);
    endtask

    task automatic write_config(logic [CFG_AW-1:0] addr, int value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[CFG_DW-1:0];
        if (addr == CFG_CURVE_ORDER) degree_reg = value & 7;
        else count_reg = value & 127;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge aclk);
        // load transactions may still be in flight
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endfunction

    function automatic logic [30:0] rand_weight(bit all_zero);
        int r;
        r = $urandom_range(0, 9);
        if (all_zero || r == 0) return '0;
        if (r == 1) return 31'($urandom);
        return 31'($urandom_range(32'h4000, 32'h30000));
    endfunction

    function automatic load_item_t mk_item(logic [1:0] req, int idx, longint param);
        load_item_t it;
        it.req    = req;
        it.idx    = idx[6:0];
        it.param  = param[31:0];
        it.weight = 31'($urandom);
        it.cx     = $urandom;
        it.cy     = $urandom;
        it.cz     = $urandom;
        return it;
    endfunction

    task automatic load_full_curve();
        load_item_t it;
        longint     kv;
        bit         wild;
        bit         zero_w;
        int         nk;
        wild   = ($urandom_range(0, 19) == 0);
        zero_w = ($urandom_range(0, 9) == 0);
        nk     = eff_count() + eff_degree() + 1;
        kv     = longint'($urandom_range(0, 32'h80000)) - 64'sh40000;
        for (int k = 0; k < nk; k++) begin
            if (wild) kv = sx32($urandom);
            else if (k > 0 && $urandom_range(0, 4) != 0) kv += $urandom_range(1, 32'h30000);
            send_item(mk_item(REQ_KNOT, k, kv));
        end
        for (int p = 0; p < eff_count(); p++) begin
            it        = mk_item(REQ_POINT, p, $urandom);
            it.weight = rand_weight(zero_w);
            it.cx     = rand_coord();
            it.cy     = rand_coord();
            it.cz     = rand_coord();
            send_item(it);
        end
    endtask

    function automatic longint rand_param();
        int r;
        int k;
        r = $urandom_range(0, 19);
        k = $urandom_range(eff_degree(), eff_count());
        if (r < 2) return sx32($urandom);
        if (r < 4) return knot_mem[k];
        return knot_mem[k] + longint'($urandom_range(0, 32'h20000)) - 64'sh10000;
    endfunction

    task automatic run_phase(int deg, int cnt, bit hold = 0);
        load_item_t it;
        int         r;
        int         evals;
        wait_drained();
        write_config(CFG_CURVE_ORDER, deg);
        write_config(CFG_POINT_COUNT, cnt);
        load_full_curve();
        // result side blocked while evaluates keep coming
        if (hold) long_hold_req = 1;
        evals = (eff_degree() >= 5) ? 3 : 20;
        while (evals > 0) begin
            r = $urandom_range(0, 19);
            if (r < 12) begin
                send_item(mk_item(REQ_EVAL, $urandom_range(0, 127), rand_param()));
                evals--;
            end else if (r < 14) begin
                send_item(mk_item(REQ_KNOT,
                    $urandom_range(0, eff_count() + eff_degree()), rand_param()));
            end else if (r < 17) begin
                it        = mk_item(REQ_POINT, $urandom_range(0, eff_count() - 1), 0);
                it.weight = rand_weight(0);
                it.cx     = rand_coord();
                send_item(it);
            end else if (r == 17) begin
                send_item(mk_item(REQ_NONE, $urandom_range(0, 127), $urandom));
            end else if (r == 18) begin
                send_item(mk_item(REQ_KNOT, $urandom_range(KNOT_DEPTH, 127), $urandom));
            end else begin
                send_item(mk_item(REQ_POINT, $urandom_range(MAX_POINTS, 127), $urandom));
            end
        end
    endtask

    // result side: checking, random stalls and the long hold-off
    initial begin
        int        stall_cnt;
        curve_pt_t exp_pt;
        stall_cnt = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pending_pts.size() == 0) begin
                    $error("curve point with no evaluate pending");
                    errors++;
                end else begin
                    exp_pt = pending_pts.pop_front();
                    if (m_tdata[31:0] !== exp_pt.px) begin
                        $error("point_x exp %h got %h", exp_pt.px, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[63:32] !== exp_pt.py) begin
                        $error("point_y exp %h got %h", exp_pt.py, m_tdata[63:32]);
                        errors++;
                    end
                    if (m_tdata[95:64] !== exp_pt.pz) begin
                        $error("point_z exp %h got %h", exp_pt.pz, m_tdata[95:64]);
                        errors++;
                    end
                    if (m_tdata[102:96] !== exp_pt.seg) begin
                        $error("segment_found exp %0d got %0d", exp_pt.seg, m_tdata[102:96]);
                        errors++;
                    end
                    if (m_tuser[0] !== exp_pt.zden) begin
                        $error("zero_denominator exp %b got %b", exp_pt.zden, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== exp_pt.sat) begin
                        $error("saturated exp %b got %b", exp_pt.sat, m_tuser[1]);
                        errors++;
                    end
                end
            end
            if (long_hold_req) begin
                long_hold_req = 0;
                stall_cnt     = LONG_HOLD;
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0) stall_cnt = $urandom_range(1, 7);
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        dir_row_t  rows[$];
        dir_row_t  row;
        curve_pt_t p0;
        int        phase_no;
        longint    one;
        one           = 64'sd1 <<< FRAC_BITS;
        errors        = 0;
        items_sent    = 0;
        idle_on       = 1;
        long_hold_req = 0;
        degree_reg    = 3;
        count_reg     = 4;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = REQ_NONE;

        // clamped cubic Bezier over [0, 1]
        for (int k = 0; k < 8; k++) begin
            row = '{it: mk_item(REQ_KNOT, k, (k < 4) ? 0 : one), has_exp: 0,
                    pt: '{default: '0}};
            rows.push_back(row);
        end
        for (int p = 0; p < 4; p++) begin
            row = '{it: mk_item(REQ_POINT, p, 0), has_exp: 0, pt: '{default: '0}};
            row.it.weight = 31'(one);
            row.it.cx = 32'(100 * one);
            row.it.cy = 32'(-200 * one);
            row.it.cz = 32'(p * one);
            if (p == 3) begin
                row.it.cx = 32'h7fff_ffff;
                row.it.cy = 32'h8000_0000;
            end
            rows.push_back(row);
        end
        p0 = '{px: 32'(100 * one), py: 32'(-200 * one), pz: '0, seg: 7'd3, zden: 0, sat: 0};
        // start of the curve is control point 0
        rows.push_back('{it: mk_item(REQ_EVAL, 0, 0), has_exp: 1, pt: p0});
        rows.push_back('{it: mk_item(REQ_EVAL, 0, one), has_exp: 0, pt: p0});
        rows.push_back('{it: mk_item(REQ_EVAL, 0, one / 2), has_exp: 0, pt: p0});
        rows.push_back('{it: mk_item(REQ_EVAL, 0, 32'sh8000_0000), has_exp: 0, pt: p0});
        rows.push_back('{it: mk_item(REQ_EVAL, 127, 32'sh7fff_ffff), has_exp: 0, pt: p0});
        // ignored items
        rows.push_back('{it: mk_item(REQ_NONE, 5, 0), has_exp: 0, pt: p0});
        rows.push_back('{it: mk_item(REQ_KNOT, 127, 32'h1234_5678), has_exp: 0, pt: p0});
        rows.push_back('{it: mk_item(REQ_POINT, 64, 0), has_exp: 0, pt: p0});
        // zero weight at point 0: basis sum vanishes at t = 0
        row = '{it: mk_item(REQ_POINT, 0, 0), has_exp: 0, pt: p0};
        row.it.weight = '0;
        row.it.cx = 32'(100 * one);
        row.it.cy = 32'(-200 * one);
        row.it.cz = '0;
        rows.push_back(row);
        p0.zden = 1;
        rows.push_back('{it: mk_item(REQ_EVAL, 0, 0), has_exp: 1, pt: p0});
        row.it.weight = 31'h7fff_ffff;
        rows.push_back(row);
        rows.push_back('{it: mk_item(REQ_EVAL, 0, 0), has_exp: 0, pt: p0});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[n]) send_item(rows[n].it, rows[n].has_exp, rows[n].pt);

        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase_no)
                0: run_phase(1, 2);
                1: run_phase(7, 64);
                2: run_phase(0, 0);
                3: run_phase(2, 6, 1);
                4: run_phase(7, 127);
                5: run_phase(1, 64);
                6: run_phase(7, 8);
                default: run_phase($urandom_range(1, 3), $urandom_range(2, 12));
            endcase
            phase_no++;
            if (items_sent > ITEM_TARGET * 85 / 100) idle_on = 0;
        end

        s_tvalid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ncpe_pkg.sv
rtl/ncpe_ram.sv
rtl/ncpe_div.sv
rtl/nurbs_curve_point_eval.sv
tb/tb_nurbs_curve_point_eval.sv
